### hdl/bfs_pkg.sv
// Shared types and constants for the best fraction search block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package bfs_pkg;

    localparam int GAIN_W     = 24;
    localparam int MAG_W      = 23;
    localparam int OUT_W      = 7;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic last_pair;
    } t_dp_sts;

endpackage

### hdl/bfs_ctrl.sv
// Controller for the best fraction search: sequences load, search, drain and publish.
// Depends on bfs_pkg for the command and status structs.
`timescale 1ns / 1ps

module bfs_ctrl
    import bfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SEARCH  = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;
    localparam logic [1:0] ST_PUBLISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_pair) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_PUBLISH;
            end
            ST_PUBLISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/bfs_datapath.sv
// Datapath for the best fraction search: pair counters, G*d accumulator,
// error stage, cross-multiplied compare and kept/result registers. Uses bfs_pkg.
`timescale 1ns / 1ps

module bfs_datapath
    import bfs_pkg::*;
#(
    parameter int MAX_TERM      = 127,
    parameter int FRACTION_BITS = 16
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [GAIN_W-1:0] i_gain_value,
    output logic [OUT_W-1:0]  o_best_numerator,
    output logic [OUT_W-1:0]  o_best_denominator
);

    localparam int TW  = $clog2(MAX_TERM + 1);
    localparam int GDW = MAG_W + TW;
    localparam int AW  = TW + FRACTION_BITS;
    localparam int EW  = (GDW > AW) ? GDW : AW;
    localparam int PW  = EW + TW;

    localparam logic [TW-1:0] TERM_MAX = TW'(MAX_TERM);
    localparam logic [TW-1:0] TERM_ONE = TW'(1);

    logic [MAG_W-1:0]  r_mag;
    logic [TW-1:0]     r_n;
    logic [TW-1:0]     r_d;
    logic [GDW-1:0]    r_gd;

    logic [EW-1:0]     r_e;
    logic [TW-1:0]     r_en;
    logic [TW-1:0]     r_ed;
    logic              r_ev;

    logic [EW-1:0]     r_ke;
    logic [TW-1:0]     r_kbd;
    logic [TW-1:0]     r_kn;
    logic [TW-1:0]     r_kd;

    logic [OUT_W-1:0]  r_out_n;
    logic [OUT_W-1:0]  r_out_d;

    logic [GAIN_W-1:0] neg_gain;
    logic [MAG_W-1:0]  mag;
    logic [EW-1:0]     a_ext;
    logic [EW-1:0]     b_ext;
    logic [EW-1:0]     e;
    logic [PW-1:0]     lhs;
    logic [PW-1:0]     rhs;
    logic              better;

    always_comb begin
        neg_gain = GAIN_W'(0) - i_gain_value;
        if (!i_gain_value[GAIN_W-1]) begin
            mag = i_gain_value[MAG_W-1:0];
        end else if (neg_gain[GAIN_W-1]) begin
            mag = {MAG_W{1'b1}};
        end else begin
            mag = neg_gain[MAG_W-1:0];
        end
    end

    assign a_ext = EW'({r_n, {FRACTION_BITS{1'b0}}});
    assign b_ext = EW'(r_gd);
    assign e     = (a_ext >= b_ext) ? (a_ext - b_ext) : (b_ext - a_ext);

    assign lhs    = PW'(r_e) * PW'(r_kbd);
    assign rhs    = PW'(r_ke) * PW'(r_ed);
    assign better = r_ev && (lhs < rhs);

    assign o_sts.last_pair = (r_n == TERM_MAX) && (r_d == TERM_MAX);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= mag;
            r_n   <= '0;
            r_d   <= TERM_ONE;
            r_gd  <= GDW'(mag);
        end else if (i_cmd.step) begin
            if (r_d == TERM_MAX) begin
                r_d  <= TERM_ONE;
                r_n  <= r_n + TERM_ONE;
                r_gd <= GDW'(r_mag);
            end else begin
                r_d  <= r_d + TERM_ONE;
                r_gd <= r_gd + GDW'(r_mag);
            end
        end
        r_e  <= e;
        r_en <= r_n;
        r_ed <= r_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else begin
            r_ev <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ke  <= EW'(mag);
            r_kbd <= TERM_ONE;
            r_kn  <= '0;
            r_kd  <= TERM_MAX;
        end else if (better) begin
            r_ke  <= r_e;
            r_kbd <= r_ed;
            r_kn  <= r_en;
            r_kd  <= r_ed;
        end
        if (i_cmd.publish) begin
            r_out_n <= OUT_W'(r_kn);
            r_out_d <= OUT_W'(r_kd);
        end
    end

    assign o_best_numerator   = r_out_n;
    assign o_best_denominator = r_out_d;

endmodule

### hdl/best_fraction_search_core.sv
// Top level of the best fraction search: stream ports around bfs_ctrl and bfs_datapath.
// Depends on bfs_pkg, bfs_ctrl and bfs_datapath.
`timescale 1ns / 1ps
//
// channel   direction  width  fields (low bit first)
// s_axis    in         24     gain_value[23:0]
// m_axis    out        16     best_numerator[6:0], best_denominator[13:7], zeros[15:14]
//
// The search visits one numerator/denominator pair per cycle through the compare stage.
// s_axis_tready is high only while no search runs; a finished result waits in the
// output register while the next gain is taken. Reset (i_rst_n low, synchronous)
// empties the output and returns to idle.

module best_fraction_search_core
    import bfs_pkg::*;
#(
    parameter int MAX_TERM      = 127,
    parameter int FRACTION_BITS = 16
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // gain_value[23:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // best_numerator[6:0], best_denominator[13:7]
);

    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;
    logic [OUT_W-1:0] best_numerator;
    logic [OUT_W-1:0] best_denominator;

    bfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    bfs_datapath #(
        .MAX_TERM      (MAX_TERM),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_sts              (dp_sts),
        .i_gain_value       (s_axis_tdata[GAIN_W-1:0]),
        .o_best_numerator   (best_numerator),
        .o_best_denominator (best_denominator)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - 2 * OUT_W){1'b0}}, best_denominator, best_numerator};

endmodule

### hdl/bfs_checker.sv
// Port-level checks for best_fraction_search_core, attached by bind.
// Depends on the top level's port list and its MAX_TERM parameter.
`timescale 1ns / 1ps

module bfs_checker #(
    parameter int MAX_TERM = 127
)(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    localparam logic [6:0] TERM_MAX_LOW = 7'(MAX_TERM);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("gain taken while a search was starting");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared one cycle after a gain transfer");

    a_zero_numerator: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[6:0] == 7'd0) |-> m_axis_tdata[13:7] == TERM_MAX_LOW)
        else $error("zero numerator without the largest denominator");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:14] == 2'b00)
        else $error("padding bits of result not zero");

endmodule

bind best_fraction_search_core bfs_checker #(.MAX_TERM(MAX_TERM)) u_bfs_checker (.*);
